@@ rtl/rm2q_pkg.sv @@
// shared constants, types and codes for the rotation matrix to quaternion pipeline
package rm2q_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ELEM_W    = 16;
	localparam int NLANE     = 3;

	// positive radicand magnitude, and a signed width that also holds the negative cases
	localparam int RAD_W  = $clog2(3 * 32768 + (1 << FRAC_BITS) + 1);
	localparam int RADS_W = RAD_W + 1;
	localparam int SQ_W   = RAD_W + FRAC_BITS;
	localparam int ROOT_W = (SQ_W + 1) / 2;
	localparam int SQX_W  = 2 * ROOT_W;
	localparam int SREM_W = ROOT_W + 2;

	localparam int D_W    = ELEM_W + 1;
	localparam int MAG_W  = ELEM_W + 1;
	localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
	localparam int QB     = ELEM_W;
	localparam int DEN_W  = ROOT_W + 1;
	localparam int REM_W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
	localparam int HX_W   = ROOT_W + ELEM_W;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [RADS_W-1:0] rads_t;
	typedef logic [RAD_W-1:0]         rad_t;
	typedef logic [SQX_W-1:0]         sqx_t;
	typedef logic [SREM_W-1:0]        srem_t;
	typedef logic [ROOT_W-1:0]        root_t;
	typedef logic signed [D_W-1:0]    d_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [DEN_W-1:0]         den_t;
	typedef logic [REM_W-1:0]         rem_t;
	typedef logic [QB-1:0]            q_t;
	typedef logic [HX_W-1:0]          hx_t;

	localparam rads_t ONE_R   = rads_t'(1) << FRAC_BITS;
	localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

	// quaternion component codes: which one comes from the square root
	typedef enum logic [1:0] {
		COMP_W = 2'd0,
		COMP_X = 2'd1,
		COMP_Y = 2'd2,
		COMP_Z = 2'd3
	} comp_t;

	// the three non-root components, in ascending component order
	typedef struct packed {
		logic [NLANE-1:0][D_W-1:0] d;
		comp_t                     slot;
		logic                      bad;
	} side_t;

endpackage

@@ rtl/rm2q_prep.sv @@
// front end: trace, pivot choice, radicand and off-diagonal sums in two stages
module rm2q_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  rm2q_pkg::elem_t m00,
	input  rm2q_pkg::elem_t m01,
	input  rm2q_pkg::elem_t m02,
	input  rm2q_pkg::elem_t m10,
	input  rm2q_pkg::elem_t m11,
	input  rm2q_pkg::elem_t m12,
	input  rm2q_pkg::elem_t m20,
	input  rm2q_pkg::elem_t m21,
	input  rm2q_pkg::elem_t m22,
	output logic            v_o,
	output rm2q_pkg::rad_t  rad_o,
	output rm2q_pkg::side_t side_o
);

	rm2q_pkg::rads_t e00, e11, e22, tr;
	rm2q_pkg::rads_t rt_c, r0_c, r1_c, r2_c;
	rm2q_pkg::d_t    da, db, dc, sp, sq, sr;
	logic            i1;
	rm2q_pkg::elem_t dmax;
	logic [1:0]      isel;

	assign e00 = rm2q_pkg::rads_t'(m00);
	assign e11 = rm2q_pkg::rads_t'(m11);
	assign e22 = rm2q_pkg::rads_t'(m22);
	assign tr   = e00 + e11 + e22;
	assign rt_c = tr + rm2q_pkg::ONE_R;
	assign r0_c = e00 - (e11 + e22) + rm2q_pkg::ONE_R;
	assign r1_c = e11 - (e22 + e00) + rm2q_pkg::ONE_R;
	assign r2_c = e22 - (e00 + e11) + rm2q_pkg::ONE_R;

	assign da = rm2q_pkg::d_t'(m21) - rm2q_pkg::d_t'(m12);
	assign db = rm2q_pkg::d_t'(m02) - rm2q_pkg::d_t'(m20);
	assign dc = rm2q_pkg::d_t'(m10) - rm2q_pkg::d_t'(m01);
	assign sp = rm2q_pkg::d_t'(m21) + rm2q_pkg::d_t'(m12);
	assign sq = rm2q_pkg::d_t'(m02) + rm2q_pkg::d_t'(m20);
	assign sr = rm2q_pkg::d_t'(m10) + rm2q_pkg::d_t'(m01);

	// ties keep the lower index
	assign i1   = m11 > m00;
	assign dmax = i1 ? m11 : m00;
	assign isel = (m22 > dmax) ? 2'd2 : {1'b0, i1};

	logic            v_s1;
	logic            trpos_s1;
	logic [1:0]      isel_s1;
	rm2q_pkg::rads_t rt_s1, r0_s1, r1_s1, r2_s1;
	rm2q_pkg::d_t    da_s1, db_s1, dc_s1, sp_s1, sq_s1, sr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trpos_s1 <= (tr > 0);
			isel_s1  <= isel;
			rt_s1    <= rt_c;
			r0_s1    <= r0_c;
			r1_s1    <= r1_c;
			r2_s1    <= r2_c;
			da_s1    <= da;
			db_s1    <= db;
			dc_s1    <= dc;
			sp_s1    <= sp;
			sq_s1    <= sq;
			sr_s1    <= sr;
		end
	end

	rm2q_pkg::rads_t rad_sel;
	rm2q_pkg::side_t side_c;

	always_comb begin
		side_c = '0;
		if (trpos_s1) begin
			rad_sel     = rt_s1;
			side_c.slot = rm2q_pkg::COMP_W;
			side_c.d[0] = da_s1;
			side_c.d[1] = db_s1;
			side_c.d[2] = dc_s1;
		end else begin
			case (isel_s1)
				2'd0: begin
					rad_sel     = r0_s1;
					side_c.slot = rm2q_pkg::COMP_X;
					side_c.d[0] = da_s1;
					side_c.d[1] = sr_s1;
					side_c.d[2] = sq_s1;
				end
				2'd1: begin
					rad_sel     = r1_s1;
					side_c.slot = rm2q_pkg::COMP_Y;
					side_c.d[0] = db_s1;
					side_c.d[1] = sr_s1;
					side_c.d[2] = sp_s1;
				end
				default: begin
					rad_sel     = r2_s1;
					side_c.slot = rm2q_pkg::COMP_Z;
					side_c.d[0] = dc_s1;
					side_c.d[1] = sq_s1;
					side_c.d[2] = sp_s1;
				end
			endcase
		end
		side_c.bad = !trpos_s1 && (rad_sel <= 0);
	end

	logic            v_s2;
	rm2q_pkg::rad_t  rad_s2;
	rm2q_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s2  <= side_c.bad ? '0 : rad_sel[rm2q_pkg::RAD_W-1:0];
			side_s2 <= side_c;
		end
	end

	assign v_o    = v_s2;
	assign rad_o  = rad_s2;
	assign side_o = side_s2;

endmodule

@@ rtl/rm2q_sqrt.sv @@
// pipelined digit-by-digit integer square root, one root bit per stage
module rm2q_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            v_i,
	input  rm2q_pkg::rad_t  rad_i,
	input  rm2q_pkg::side_t side_i,
	output logic            v_o,
	output rm2q_pkg::root_t root_o,
	output rm2q_pkg::side_t side_o
);

	rm2q_pkg::sqx_t  x_s    [0:rm2q_pkg::ROOT_W];
	rm2q_pkg::srem_t rem_s  [0:rm2q_pkg::ROOT_W];
	rm2q_pkg::root_t root_s [0:rm2q_pkg::ROOT_W];
	rm2q_pkg::side_t side_s [0:rm2q_pkg::ROOT_W];
	logic            v_s    [0:rm2q_pkg::ROOT_W];

	// radicand carries the extra fraction bits of the root
	assign x_s[0]    = rm2q_pkg::sqx_t'({rad_i, {rm2q_pkg::FRAC_BITS{1'b0}}});
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_i;
	assign v_s[0]    = v_i;

	for (genvar g = 0; g < rm2q_pkg::ROOT_W; g++) begin : g_step
		rm2q_pkg::srem_t rsh, trial, diff;
		logic            ge;

		assign rsh   = {rem_s[g][rm2q_pkg::ROOT_W-1:0],
			x_s[g][rm2q_pkg::SQX_W-1-2*g -: 2]};
		assign trial = {root_s[g], 2'b01};
		assign ge    = rsh >= trial;
		assign diff  = rsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[g+1]    <= x_s[g];
				rem_s[g+1]  <= ge ? diff : rsh;
				root_s[g+1] <= {root_s[g][rm2q_pkg::ROOT_W-2:0], ge};
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign v_o    = v_s[rm2q_pkg::ROOT_W];
	assign root_o = root_s[rm2q_pkg::ROOT_W];
	assign side_o = side_s[rm2q_pkg::ROOT_W];

endmodule

@@ rtl/rm2q_div.sv @@
// three pipelined restoring dividers sharing one denominator, one quotient bit per stage
module rm2q_div (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       adv,
	input  logic                                       v_i,
	input  rm2q_pkg::root_t                            root_i,
	input  rm2q_pkg::side_t                            side_i,
	output logic                                       v_o,
	output rm2q_pkg::root_t                            root_o,
	output rm2q_pkg::side_t                            side_o,
	output logic [rm2q_pkg::NLANE-1:0][rm2q_pkg::QB-1:0] q_o,
	output logic [rm2q_pkg::NLANE-1:0]                 ovf_o
);

	localparam int NS = rm2q_pkg::QB + 1;

	// first stage: numerator with rounding term, overflow check
	rm2q_pkg::den_t den_c;
	rm2q_pkg::rem_t num_c [rm2q_pkg::NLANE];
	logic [rm2q_pkg::NLANE-1:0] ovf_c;

	assign den_c = {root_i, 1'b0};

	always_comb begin
		rm2q_pkg::d_t   dv;
		rm2q_pkg::mag_t mag;
		for (int l = 0; l < rm2q_pkg::NLANE; l++) begin
			dv       = side_i.d[l];
			mag      = rm2q_pkg::mag_t'(dv[rm2q_pkg::D_W-1] ? -dv : dv);
			num_c[l] = rm2q_pkg::rem_t'({mag, {rm2q_pkg::FRAC_BITS{1'b0}}})
				+ rm2q_pkg::rem_t'(root_i);
			ovf_c[l] = num_c[l] >= (rm2q_pkg::rem_t'(den_c) << rm2q_pkg::QB);
		end
	end

	rm2q_pkg::rem_t                            rem_s  [1:NS][rm2q_pkg::NLANE];
	logic [rm2q_pkg::NLANE-1:0][rm2q_pkg::QB-1:0] q_s [1:NS];
	logic [rm2q_pkg::NLANE-1:0]                ovf_s  [1:NS];
	rm2q_pkg::den_t                            den_s  [1:NS];
	rm2q_pkg::root_t                           root_s [1:NS];
	rm2q_pkg::side_t                           side_s [1:NS];
	logic                                      v_s    [1:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[1] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < rm2q_pkg::NLANE; l++) begin
				rem_s[1][l] <= num_c[l];
			end
			q_s[1]    <= '0;
			ovf_s[1]  <= ovf_c;
			den_s[1]  <= den_c;
			root_s[1] <= root_i;
			side_s[1] <= side_i;
		end
	end

	for (genvar g = 1; g < NS; g++) begin : g_bit
		rm2q_pkg::rem_t                            sh;
		rm2q_pkg::rem_t                            nrem [rm2q_pkg::NLANE];
		logic [rm2q_pkg::NLANE-1:0][rm2q_pkg::QB-1:0] nq;

		assign sh = rm2q_pkg::rem_t'(den_s[g]) << (rm2q_pkg::QB - g);

		always_comb begin
			logic ge;
			nq = q_s[g];
			for (int l = 0; l < rm2q_pkg::NLANE; l++) begin
				ge                       = rem_s[g][l] >= sh;
				nrem[l]                  = ge ? rem_s[g][l] - sh : rem_s[g][l];
				nq[l][rm2q_pkg::QB - g]  = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < rm2q_pkg::NLANE; l++) begin
					rem_s[g+1][l] <= nrem[l];
				end
				q_s[g+1]    <= nq;
				ovf_s[g+1]  <= ovf_s[g];
				den_s[g+1]  <= den_s[g];
				root_s[g+1] <= root_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign v_o    = v_s[NS];
	assign root_o = root_s[NS];
	assign side_o = side_s[NS];
	assign q_o    = q_s[NS];
	assign ovf_o  = ovf_s[NS];

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// top level: rotation matrix to quaternion pipeline with output saturation stage
//
//  channel  signals                          payload
//  -------  -------------------------------  ------------------------------
//  input    in_valid, in_stall               m00 m01 m02 m10 m11 m12 m20 m21 m22
//  output   out_valid, out_stall             qw qx qy qz bad_input
//
// one matrix per cycle while the output is not held; stages: 2 front-end stages, one stage per
// root bit in the square root (16), 17 divider stages, one output stage.
// arst_n clears only the valid bits of every stage.
// a held output transfer freezes the whole pipeline; in_stall follows it.
module rotation_matrix_to_quaternion (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rm2q_pkg::elem_t m00,
	input  rm2q_pkg::elem_t m01,
	input  rm2q_pkg::elem_t m02,
	input  rm2q_pkg::elem_t m10,
	input  rm2q_pkg::elem_t m11,
	input  rm2q_pkg::elem_t m12,
	input  rm2q_pkg::elem_t m20,
	input  rm2q_pkg::elem_t m21,
	input  rm2q_pkg::elem_t m22,
	output logic            out_valid,
	input  logic            out_stall,
	output rm2q_pkg::elem_t qw,
	output rm2q_pkg::elem_t qx,
	output rm2q_pkg::elem_t qy,
	output rm2q_pkg::elem_t qz,
	output logic            bad_input
);

	logic adv;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	logic            pv;
	rm2q_pkg::rad_t  prad;
	rm2q_pkg::side_t pside;

	rm2q_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (in_valid),
		.m00    (m00),
		.m01    (m01),
		.m02    (m02),
		.m10    (m10),
		.m11    (m11),
		.m12    (m12),
		.m20    (m20),
		.m21    (m21),
		.m22    (m22),
		.v_o    (pv),
		.rad_o  (prad),
		.side_o (pside)
	);

	logic            sv;
	rm2q_pkg::root_t sroot;
	rm2q_pkg::side_t sside;

	rm2q_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_i    (pv),
		.rad_i  (prad),
		.side_i (pside),
		.v_o    (sv),
		.root_o (sroot),
		.side_o (sside)
	);

	logic                                         dv;
	rm2q_pkg::root_t                              droot;
	rm2q_pkg::side_t                              dside;
	logic [rm2q_pkg::NLANE-1:0][rm2q_pkg::QB-1:0] dq;
	logic [rm2q_pkg::NLANE-1:0]                   dovf;

	rm2q_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_i    (sv),
		.root_i (sroot),
		.side_i (sside),
		.v_o    (dv),
		.root_o (droot),
		.side_o (dside),
		.q_o    (dq),
		.ovf_o  (dovf)
	);

	// halving of the root, sign and saturation per component
	logic [3:0][rm2q_pkg::ELEM_W-1:0] res_c;

	always_comb begin
		rm2q_pkg::hx_t hx;
		logic [1:0]    ln;
		logic          neg;
		rm2q_pkg::q_t  qq;
		logic          o;
		hx = rm2q_pkg::hx_t'(droot >> 1);
		for (int c = 0; c < 4; c++) begin
			ln  = (2'(c) > dside.slot) ? 2'(c) - 2'd1 : 2'(c);
			neg = dside.d[ln][rm2q_pkg::D_W-1];
			qq  = dq[ln];
			o   = dovf[ln];
			if (dside.bad) begin
				res_c[c] = '0;
			end else if (2'(c) == dside.slot) begin
				res_c[c] = (hx > rm2q_pkg::hx_t'(rm2q_pkg::SAT_POS)) ? rm2q_pkg::SAT_POS
					: hx[rm2q_pkg::ELEM_W-1:0];
			end else if (!neg) begin
				res_c[c] = (o || qq > rm2q_pkg::SAT_POS) ? rm2q_pkg::SAT_POS : qq;
			end else begin
				res_c[c] = (o || qq > rm2q_pkg::SAT_NEG) ? rm2q_pkg::SAT_NEG : -qq;
			end
		end
	end

	logic                             v_s36;
	logic [3:0][rm2q_pkg::ELEM_W-1:0] res_s36;
	logic                             bad_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s36 <= 1'b0;
		end else if (adv) begin
			v_s36 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s36 <= res_c;
			bad_s36 <= dside.bad;
		end
	end

	assign out_valid = v_s36;
	assign qw        = res_s36[0];
	assign qx        = res_s36[1];
	assign qy        = res_s36[2];
	assign qz        = res_s36[3];
	assign bad_input = bad_s36;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_input |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
		else $error("flagged result carries nonzero components");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_input |-> qw != 0 || qx != 0 || qy != 0 || qz != 0)
		else $error("valid quaternion with all components zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(qw) && $stable(qz)
			&& $stable(bad_input))
		else $error("pipeline moved while output was held");

endmodule
